@@ rtl/lbd_pkg.sv @@
package lbd_pkg;

  localparam int unsigned LIT_BITS = 8;
  localparam int unsigned LEN_BITS = 4;
  localparam int unsigned LEN_BIAS = 3;
  localparam int unsigned COUNT_W  = 31;
  // copy length counter: at most 15 + LEN_BIAS bytes
  localparam int unsigned LEFT_W   = 5;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_OVER  = 2'd1;
  localparam logic [1:0] STAT_SHORT = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PARSE,
    ST_CRD,
    ST_CEM,
    ST_FLUSH
  } lbd_state_t;

  typedef struct packed {
    logic [LIT_BITS-1:0] data;
    logic                is_status;
    logic [1:0]          status;
  } lbd_result_t;

  typedef struct packed {
    logic        push;
    logic        flush;
    lbd_result_t res;
  } lbd_stage_req_t;

  typedef struct packed {
    logic push_ok;
    logic flush_ok;
  } lbd_stage_stat_t;

endpackage

@@ rtl/lbd_ram.sv @@
module lbd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/lbd_out_stage.sv @@
// Hold the newest result one slot back so run_end can be set once the
// sequencer knows whether another result follows in the same run.
module lbd_out_stage (
  input  logic                    clk,
  input  logic                    rst_n,
  input  lbd_pkg::lbd_stage_req_t req,
  output lbd_pkg::lbd_stage_stat_t stat,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [7:0]              out_tdata,
  output logic [2:0]              out_tuser,
  output logic                    out_tlast
);

  logic                  stage_v_r;
  lbd_pkg::lbd_result_t  stage_r;
  logic                  out_v_r;
  lbd_pkg::lbd_result_t  out_r;
  logic                  last_r;
  logic                  out_free;

  assign out_free      = !out_v_r || out_tready;
  assign stat.push_ok  = !stage_v_r || out_free;
  assign stat.flush_ok = !stage_v_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      if (out_tready) begin
        out_v_r <= 1'b0;
      end
      if (req.push && stat.push_ok) begin
        // advance the held result, keep the new one back
        if (stage_v_r) begin
          out_v_r <= 1'b1;
          out_r   <= stage_r;
          last_r  <= 1'b0;
        end
        stage_r   <= req.res;
        stage_v_r <= 1'b1;
      end else if (req.flush && stat.flush_ok && stage_v_r) begin
        out_v_r   <= 1'b1;
        out_r     <= stage_r;
        last_r    <= 1'b1;
        stage_v_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_r.data;
  assign out_tuser  = {out_r.status, out_r.is_status};
  assign out_tlast  = last_r;

  ap_push_flush_excl: assert property (@(posedge clk) disable iff (!rst_n)
    req.push |-> !req.flush) else $error("push and flush together");
  ap_flush_empties: assert property (@(posedge clk) disable iff (!rst_n)
    req.flush && stat.flush_ok |=> !stage_v_r) else $error("flush left a held result");
  ap_last_has_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(stage_v_r) && !$past(out_v_r) |-> !out_v_r)
    else $error("output loaded from an empty hold slot");

endmodule

@@ rtl/lzss_bitstream_decoder.sv @@
// Sequence: an item is taken in the idle state, then each token is parsed in
// turn; each copied byte is a window read, then an emit and write back. An
// unfinished token is kept and the flush state closes the run; its last result is registered.
// A new item is taken only after the previous one is fully handled and the
// block is back in idle, so output stalls hold off the next item as well.
// Reset (rst_n, synchronous, active low) starts a fresh stream; unwritten window reads 0.
module lzss_bitstream_decoder #(
  parameter int unsigned WINDOW_BITS = 13
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: [7:0] in_byte
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  // in_tuser: [0] first_of_stream
  input  logic        in_tuser,
  // in_tlast: last_of_stream
  input  logic        in_tlast,
  // out_tdata: [7:0] out_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,
  // out_tuser: [0] is_status, [2:1] status
  output logic [2:0]  out_tuser,
  // out_tlast: run_end
  output logic        out_tlast,
  // cfg_data: [30:0] declared decoded length of the stream
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [30:0] cfg_data
);

  localparam int unsigned W       = WINDOW_BITS;
  localparam int unsigned AW      = W + 12;         // bit accumulator
  localparam int unsigned TW      = W + 4;          // longest incomplete token
  localparam int unsigned NW      = $clog2(AW + 1);
  localparam int unsigned LIT_TOK = 1 + lbd_pkg::LIT_BITS;
  localparam int unsigned OFF_TOK = 1 + W;
  localparam int unsigned MAT_TOK = 1 + W + lbd_pkg::LEN_BITS;

  lbd_pkg::lbd_state_t state_r, state_nxt;

  logic [AW-1:0]              acc_r, acc_nxt;     // left aligned, next bit at top
  logic [NW-1:0]              acc_n_r, acc_n_nxt;
  logic                       pad_r, pad_nxt;
  logic [TW-1:0]              tok_r, tok_nxt;
  logic [NW-1:0]              cnt_r, cnt_nxt;
  logic [W-1:0]               wp_r, wp_nxt;
  logic [lbd_pkg::COUNT_W-1:0] prod_r, prod_nxt;
  logic                       done_r, done_nxt;
  logic [W-1:0]               off_r, off_nxt;
  logic [lbd_pkg::LEFT_W-1:0] left_r, left_nxt;
  logic [W-1:0]               hwm_r, hwm_nxt;     // highest entry written so far
  logic                       seen_r, seen_nxt;   // every entry has been written
  logic                       vld_r, vld_nxt;
  logic [lbd_pkg::COUNT_W-1:0] expected_r;

  logic                       ram_we, ram_re;
  logic [W-1:0]               ram_raddr;
  logic [7:0]                 ram_rdata;
  logic                       do_emit;
  logic [7:0]                 emit_val;
  logic                       over;
  logic [W-1:0]               tok_off;
  logic [lbd_pkg::LEN_BITS-1:0] tok_len;
  logic [TW-1:0]              in_tok;
  logic [NW-1:0]              in_cnt;

  lbd_pkg::lbd_stage_req_t  req;
  lbd_pkg::lbd_stage_stat_t stat;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == lbd_pkg::ST_IDLE);
  assign over      = (prod_r >= expected_r);
  assign tok_off   = acc_r[AW-2 -: W];
  assign tok_len   = acc_r[AW-2-W -: lbd_pkg::LEN_BITS];
  assign in_tok    = in_tuser ? '0 : tok_r;
  assign in_cnt    = in_tuser ? '0 : cnt_r;

  lbd_ram #(
    .WIDTH (8),
    .DEPTH (1 << WINDOW_BITS)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (emit_val),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lbd_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= lbd_pkg::ST_IDLE;
      pad_r      <= 1'b0;
      tok_r      <= '0;
      cnt_r      <= '0;
      acc_n_r    <= '0;
      wp_r       <= W'(1);
      prod_r     <= '0;
      done_r     <= 1'b0;
      left_r     <= '0;
      hwm_r      <= '0;
      seen_r     <= 1'b0;
      vld_r      <= 1'b0;
      expected_r <= '0;
    end else begin
      state_r <= state_nxt;
      pad_r   <= pad_nxt;
      tok_r   <= tok_nxt;
      cnt_r   <= cnt_nxt;
      acc_n_r <= acc_n_nxt;
      wp_r    <= wp_nxt;
      prod_r  <= prod_nxt;
      done_r  <= done_nxt;
      left_r  <= left_nxt;
      hwm_r   <= hwm_nxt;
      seen_r  <= seen_nxt;
      vld_r   <= vld_nxt;
      if (cfg_valid && cfg_ready) begin
        expected_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    off_r <= off_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    acc_nxt   = acc_r;
    acc_n_nxt = acc_n_r;
    pad_nxt   = pad_r;
    tok_nxt   = tok_r;
    cnt_nxt   = cnt_r;
    wp_nxt    = wp_r;
    prod_nxt  = prod_r;
    done_nxt  = done_r;
    off_nxt   = off_r;
    left_nxt  = left_r;
    hwm_nxt   = hwm_r;
    seen_nxt  = seen_r;
    vld_nxt   = vld_r;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = off_r;
    do_emit   = 1'b0;
    emit_val  = '0;
    req       = '0;

    case (state_r)
      lbd_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          // first item of a stream: restart reader, cursor and count
          if (in_tuser) begin
            tok_nxt  = '0;
            cnt_nxt  = '0;
            wp_nxt   = W'(1);
            prod_nxt = '0;
            done_nxt = 1'b0;
          end
          // drop items that arrive after the stream has ended
          if (in_tuser || !done_r) begin
            acc_nxt   = {in_tok, 8'h00} | ({in_tdata, {TW{1'b0}}} >> in_cnt);
            acc_n_nxt = in_cnt + NW'(8);
            pad_nxt   = in_tlast;
            state_nxt = lbd_pkg::ST_PARSE;
          end
        end
      end

      lbd_pkg::ST_PARSE: begin
        if (acc_n_r == '0 && !pad_r) begin
          tok_nxt   = acc_r[AW-1 -: TW];
          cnt_nxt   = acc_n_r;
          state_nxt = lbd_pkg::ST_FLUSH;
        end else if (acc_r[AW-1]) begin
          // literal token
          if (acc_n_r >= NW'(LIT_TOK) || pad_r) begin
            if (stat.push_ok) begin
              do_emit   = 1'b1;
              emit_val  = acc_r[AW-2 -: 8];
              acc_nxt   = acc_r << LIT_TOK;
              acc_n_nxt = (acc_n_r > NW'(LIT_TOK)) ? acc_n_r - NW'(LIT_TOK) : '0;
            end
          end else begin
            tok_nxt   = acc_r[AW-1 -: TW];
            cnt_nxt   = acc_n_r;
            state_nxt = lbd_pkg::ST_FLUSH;
          end
        end else if (acc_n_r >= NW'(OFF_TOK) || pad_r) begin
          if (tok_off == '0) begin
            // terminator: report status, discard remaining bits
            if (stat.push_ok) begin
              req.push          = 1'b1;
              req.res.is_status = 1'b1;
              req.res.status    = (prod_r == expected_r) ? lbd_pkg::STAT_OK
                                                         : lbd_pkg::STAT_SHORT;
              done_nxt          = 1'b1;
              tok_nxt           = '0;
              cnt_nxt           = '0;
              state_nxt         = lbd_pkg::ST_FLUSH;
            end
          end else if (acc_n_r >= NW'(MAT_TOK) || pad_r) begin
            off_nxt   = tok_off;
            left_nxt  = lbd_pkg::LEFT_W'(tok_len) + lbd_pkg::LEFT_W'(lbd_pkg::LEN_BIAS);
            acc_nxt   = acc_r << MAT_TOK;
            acc_n_nxt = (acc_n_r > NW'(MAT_TOK)) ? acc_n_r - NW'(MAT_TOK) : '0;
            state_nxt = lbd_pkg::ST_CRD;
          end else begin
            tok_nxt   = acc_r[AW-1 -: TW];
            cnt_nxt   = acc_n_r;
            state_nxt = lbd_pkg::ST_FLUSH;
          end
        end else begin
          tok_nxt   = acc_r[AW-1 -: TW];
          cnt_nxt   = acc_n_r;
          state_nxt = lbd_pkg::ST_FLUSH;
        end
      end

      lbd_pkg::ST_CRD: begin
        // read the source entry; never-written entries read as zero
        ram_re    = 1'b1;
        ram_raddr = off_r;
        vld_nxt   = seen_r || (off_r != '0 && off_r <= hwm_r);
        state_nxt = lbd_pkg::ST_CEM;
      end

      lbd_pkg::ST_CEM: begin
        if (stat.push_ok) begin
          do_emit   = 1'b1;
          emit_val  = vld_r ? ram_rdata : 8'h00;
          off_nxt   = off_r + W'(1);
          left_nxt  = left_r - lbd_pkg::LEFT_W'(1);
          state_nxt = (left_r == lbd_pkg::LEFT_W'(1)) ? lbd_pkg::ST_PARSE
                                                      : lbd_pkg::ST_CRD;
        end
      end

      lbd_pkg::ST_FLUSH: begin
        // release the held result with run_end set
        req.flush = 1'b1;
        if (stat.flush_ok) begin
          state_nxt = lbd_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = lbd_pkg::ST_IDLE;
      end
    endcase

    if (do_emit) begin
      req.push = 1'b1;
      if (over) begin
        // overflow: report and stop the stream at once
        req.res.is_status = 1'b1;
        req.res.status    = lbd_pkg::STAT_OVER;
        done_nxt          = 1'b1;
        tok_nxt           = '0;
        cnt_nxt           = '0;
        state_nxt         = lbd_pkg::ST_FLUSH;
      end else begin
        req.res.data = emit_val;
        ram_we       = 1'b1;
        wp_nxt       = wp_r + W'(1);
        prod_nxt     = prod_r + lbd_pkg::COUNT_W'(1);
        if (wp_r == '0) begin
          seen_nxt = 1'b1;
        end else if (wp_r > hwm_r) begin
          hwm_nxt = wp_r;
        end
      end
    end
  end

  ap_done_no_token: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> cnt_r == '0) else $error("token bits kept after stream end");
  ap_copy_left: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lbd_pkg::ST_CRD || state_r == lbd_pkg::ST_CEM) |-> left_r != '0)
    else $error("copy with no bytes left");
  ap_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == lbd_pkg::ST_PARSE || state_r == lbd_pkg::ST_CEM))
    else $error("window write outside emit");
  ap_read_then_emit: assert property (@(posedge clk) disable iff (!rst_n)
    ram_re |=> state_r == lbd_pkg::ST_CEM) else $error("window read not followed by emit");
  ap_token_fits: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= NW'(TW)) else $error("saved token too long");

endmodule

@@ sim/tb_lzss_bitstream_decoder.sv @@
module tb_lzss_bitstream_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LIT_BITS = lbd_pkg::LIT_BITS;
  localparam int unsigned LEN_BITS = lbd_pkg::LEN_BITS;
  localparam int unsigned LEN_BIAS = lbd_pkg::LEN_BIAS;
  localparam int unsigned WIN_BITS = 13;
  localparam int unsigned OFF_BITS = WIN_BITS;
  localparam int unsigned STOP_BITS = 1 + OFF_BITS;
  localparam int unsigned COPY_BITS = 1 + OFF_BITS + LEN_BITS;
  // Cycles to let pass after the last result before touching the register.
  localparam int unsigned DRAIN_CYCLES = 60;

  // One compressed byte with its stream markers.
  typedef struct packed {
    logic [7:0] data;
    logic       first_flag;
    logic       last_flag;
  } code_item_t;

  // One decoded result: a byte or a status, plus the end-of-run mark.
  typedef struct packed {
    logic [7:0] data;
    logic       is_status;
    logic [1:0] status;
    logic       run_end;
  } dec_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [30:0] cfg_data = '0;

  lzss_bitstream_decoder #(
    .WINDOW_BITS(WIN_BITS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Decoder state as seen from outside: history window, write cursor, byte
  // count, the leftover bits of an unfinished token and the stream-over flag.
  // ---------------------------------------------------------------------------
  logic [7:0]         hist_win [0:(1 << WIN_BITS) - 1];
  logic [WIN_BITS-1:0] wr_pos = WIN_BITS'(1);
  logic [30:0]        produced = '0;
  logic [63:0]        carry_bits = '0;
  int unsigned        carry_cnt = 0;
  bit                 stream_done = 1'b0;
  logic [30:0]        size_limit = '0;

  dec_result_t step_out[$];      // results of the item being decoded
  dec_result_t decoded_q[$];     // results still to come out of the block
  code_item_t  compressed_q[$];  // items waiting for the driver
  bit          code_bits[$];     // bit string of the stream under construction

  int unsigned n_errors = 0;
  int unsigned n_items = 0;

  initial begin
    for (int k = 0; k < (1 << WIN_BITS); k++) hist_win[k] = 8'h00;
  end

  function automatic dec_result_t mk_result(logic [7:0] b, logic is_st, logic [1:0] st);
    dec_result_t r;
    r.data = b;
    r.is_status = is_st;
    r.status = st;
    r.run_end = 1'b0;
    return r;
  endfunction

  // Emit one byte unless it would run past the declared size; in that case
  // report overflow and stop the stream.
  function automatic bit put_byte(logic [7:0] b);
    if (produced >= size_limit) begin
      step_out.insert(step_out.size(), mk_result(8'h00, 1'b1, lbd_pkg::STAT_OVER));
      stream_done = 1'b1;
      return 1'b0;
    end
    step_out.insert(step_out.size(), mk_result(b, 1'b0, lbd_pkg::STAT_OK));
    hist_win[wr_pos] = b;
    wr_pos = wr_pos + WIN_BITS'(1);
    produced = produced + 31'd1;
    return 1'b1;
  endfunction

  // Decode one accepted item and queue the results it causes.
  task automatic decode_item(code_item_t it);
    logic [63:0]         acc;
    int unsigned         acc_n;
    logic [OFF_BITS-1:0] off;
    logic [WIN_BITS-1:0] rd_idx;
    int unsigned         len;
    bit                  ok;
    dec_result_t         r;

    step_out.delete();
    if (it.first_flag) begin
      carry_bits = '0;
      carry_cnt = 0;
      wr_pos = WIN_BITS'(1);
      produced = '0;
      stream_done = 1'b0;
    end
    if (stream_done) return;

    acc = (carry_bits << 8) | 64'(it.data);
    acc_n = carry_cnt + 8;
    // At the end of a stream append zeros; 32 of them always reach a
    // terminator, whatever token was left open.
    if (it.last_flag) begin
      acc = acc << 32;
      acc_n = acc_n + 32;
    end

    ok = 1'b1;
    while (ok) begin
      if (acc_n < 1) break;
      if (acc[acc_n-1]) begin
        // literal
        if (acc_n < 1 + LIT_BITS) break;
        acc_n = acc_n - (1 + LIT_BITS);
        ok = put_byte(8'(acc >> acc_n));
      end else begin
        if (acc_n < STOP_BITS) break;
        off = OFF_BITS'(acc >> (acc_n - STOP_BITS));
        if (off == '0) begin
          // terminator: compare the count with the declared size
          step_out.insert(step_out.size(),
                          mk_result(8'h00, 1'b1, (produced == size_limit) ?
                                    lbd_pkg::STAT_OK : lbd_pkg::STAT_SHORT));
          stream_done = 1'b1;
          break;
        end
        if (acc_n < COPY_BITS) break;
        len = int'(LEN_BITS'(acc >> (acc_n - COPY_BITS))) + LEN_BIAS;
        acc_n = acc_n - COPY_BITS;
        for (int i = 0; i < len && ok; i++) begin
          rd_idx = off + WIN_BITS'(i);
          ok = put_byte(hist_win[rd_idx]);
        end
      end
    end

    if (stream_done) begin
      carry_bits = '0;
      carry_cnt = 0;
    end else begin
      carry_bits = acc & ((64'd1 << acc_n) - 64'd1);
      carry_cnt = acc_n;
    end

    for (int k = 0; k < step_out.size(); k++) begin
      r = step_out[k];
      r.run_end = (k == step_out.size() - 1);
      decoded_q.insert(decoded_q.size(), r);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stream builder: tokens are appended as bits, most significant first.
  // ---------------------------------------------------------------------------
  task automatic put_bits(logic [31:0] v, int unsigned w);
    for (int j = w - 1; j >= 0; j--) code_bits.insert(code_bits.size(), v[j]);
  endtask

  task automatic tok_literal(logic [7:0] b);
    put_bits(1, 1);
    put_bits(32'(b), LIT_BITS);
  endtask

  task automatic tok_copy(logic [OFF_BITS-1:0] off, logic [LEN_BITS-1:0] len_field);
    put_bits(0, 1);
    put_bits(32'(off), OFF_BITS);
    put_bits(32'(len_field), LEN_BITS);
  endtask

  task automatic tok_stop();
    put_bits(0, STOP_BITS);
  endtask

  // Cut the bit string into items; fill the tail of the last byte with noise.
  task automatic send_stream(bit mark_last);
    code_item_t it;
    int unsigned nbytes;
    while (code_bits.size() % 8 != 0)
      code_bits.insert(code_bits.size(), 1'($urandom_range(0, 1)));
    nbytes = code_bits.size() / 8;
    for (int k = 0; k < nbytes; k++) begin
      for (int j = 0; j < 8; j++) it.data[7-j] = code_bits[8*k + j];
      it.first_flag = (k == 0);
      it.last_flag = mark_last && (k == nbytes - 1);
      compressed_q.insert(compressed_q.size(), it);
      n_items++;
    end
    code_bits.delete();
  endtask

  task automatic push_raw(logic [7:0] b, bit f, bit l);
    code_item_t it;
    it.data = b;
    it.first_flag = f;
    it.last_flag = l;
    compressed_q.insert(compressed_q.size(), it);
  endtask

  // Random tokens that decode to exactly target bytes.
  task automatic gen_tokens(int unsigned target);
    int unsigned left;
    int unsigned top;
    int unsigned lf;
    logic [OFF_BITS-1:0] off;
    left = target;
    while (left > 0) begin
      if (left >= LEN_BIAS && $urandom_range(0, 2) != 0) begin
        top = (left > 15 + LEN_BIAS) ? 15 + LEN_BIAS : left;
        lf = $urandom_range(0, top - LEN_BIAS);
        if ($urandom_range(0, 3) == 0) off = OFF_BITS'($urandom_range(1, (1 << OFF_BITS) - 1));
        else off = OFF_BITS'($urandom_range(1, 40));
        tok_copy(off, LEN_BITS'(lf));
        left = left - (lf + LEN_BIAS);
      end else begin
        tok_literal(8'($urandom_range(0, 255)));
        left--;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: bursts of items from compressed_q with random gaps between them.
  // drv_loaded mirrors in_tvalid so that the decision is settled within the
  // edge; valid is assigned once per edge.
  // ---------------------------------------------------------------------------
  code_item_t  cur_item = '0;
  bit          drv_loaded = 1'b0;
  int unsigned gap_left = 0;
  int unsigned burst_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      // the item on the bus is taken at this edge: predict its results
      if (in_tvalid && in_tready) begin
        decode_item(cur_item);
        drv_loaded = 1'b0;
      end
      if (!drv_loaded) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (compressed_q.size() > 0) begin
          cur_item = compressed_q.pop_front();
          drv_loaded = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
      in_tvalid <= drv_loaded;
      in_tdata <= cur_item.data;
      in_tuser <= cur_item.first_flag;
      in_tlast <= cur_item.last_flag;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: ready follows one of four patterns, picked anew periodically: always
  // ready, coin toss, a fixed periodic duty, or mostly stalled.
  // ---------------------------------------------------------------------------
  int unsigned rx_cycle = 0;
  int unsigned rx_mode = 0;

  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 97 == 0) rx_mode <= $urandom_range(0, 3);
    case (rx_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      2: out_tready <= ((rx_cycle % 5) < 3);
      default: out_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare every accepted result with the oldest prediction.
  // ---------------------------------------------------------------------------
  task automatic flag_error(string msg);
    n_errors++;
    if (n_errors <= 10) $display("mismatch %0d at %0t: %s", n_errors, $realtime, msg);
  endtask

  dec_result_t mon_want;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (decoded_q.size() == 0) begin
        flag_error($sformatf("unexpected result byte %02h user %03b end %0b",
                             out_tdata, out_tuser, out_tlast));
      end else begin
        mon_want = decoded_q.pop_front();
        if (out_tdata !== mon_want.data || out_tuser[0] !== mon_want.is_status ||
            out_tuser[2:1] !== mon_want.status || out_tlast !== mon_want.run_end) begin
          flag_error($sformatf(
            "expected byte/st/code/end %02h/%0b/%0d/%0b, got %02h/%0b/%0d/%0b",
            mon_want.data, mon_want.is_status, mon_want.status, mon_want.run_end,
            out_tdata, out_tuser[0], out_tuser[2:1], out_tlast));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencing helpers.
  // ---------------------------------------------------------------------------
  // Wait until every item is taken and every result is out, then drain.
  task automatic settle();
    do @(negedge clk);
    while (compressed_q.size() != 0 || drv_loaded || decoded_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write the declared size; the block is idle here.
  task automatic write_size(logic [30:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk);
    while (!cfg_ready);
    size_limit = v;
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------
  initial begin
    logic [30:0] sz;
    int unsigned target;
    int unsigned pick;
    int unsigned phase;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Straight out of reset, size still zero, no restart marker: an all-zero
    // byte ends at once with status ok, then a byte after the end is
    // dropped, then a restarted literal overflows the zero size.
    push_raw(8'h00, 1'b0, 1'b1);
    push_raw(8'hff, 1'b0, 1'b0);
    push_raw(8'hff, 1'b1, 1'b1);
    settle();

    // Literals at both extremes, a short copy that overlaps its own output,
    // a longest copy from the farthest offset, then a clean end.
    write_size(31'd23);
    tok_literal(8'h00);
    tok_literal(8'hff);
    tok_copy('1 >> (OFF_BITS - 1), '0);
    tok_copy('1, '1);
    tok_stop();
    send_stream(1'b1);
    settle();

    // Largest size: an ended stream is short; so is one ended only by the
    // zero fill after its last byte.
    write_size(31'h7fffffff);
    tok_literal(8'ha5);
    tok_stop();
    send_stream(1'b1);
    tok_literal(8'h5a);
    send_stream(1'b1);
    settle();

    // Overflow inside a copy; the trailing byte is dropped.
    write_size(31'd2);
    tok_copy(OFF_BITS'(5), '1);
    tok_stop();
    send_stream(1'b0);
    push_raw(8'h3c, 1'b0, 1'b1);
    settle();

    n_items = 0;
    phase = 0;
    while (n_items < 310) begin
      pick = $urandom_range(0, 9);
      if (phase == 0 || pick == 0) sz = '0;
      else if (pick == 1) sz = 31'h7fffffff;
      else if (pick == 2) sz = 31'($urandom());
      else sz = 31'($urandom_range(1, 60));
      write_size(sz);
      phase++;

      repeat ($urandom_range(1, 3)) begin
        pick = $urandom_range(0, 9);
        if (sz > 200) target = $urandom_range(0, 60);
        else if (pick < 6) target = sz;
        else if (pick < 8) target = sz + $urandom_range(1, 20);
        else target = (sz == 0) ? 0 : $urandom_range(0, sz - 1);
        gen_tokens(target);

        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          tok_stop();
          send_stream($urandom_range(0, 2) != 0);
        end else if (pick == 7) begin
          // no terminator: the zero fill closes the stream
          send_stream(1'b1);
        end else if (pick == 8) begin
          // broken: neither terminator nor end marker, next restart cuts it
          send_stream(1'b0);
        end else begin
          tok_stop();
          send_stream(1'b0);
        end

        // occasional raw bytes with random markers
        if ($urandom_range(0, 5) == 0) begin
          repeat ($urandom_range(1, 4))
            push_raw(8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0),
                     ($urandom_range(0, 3) == 0));
        end
      end
      settle();
    end

    if (n_errors == 0) begin
      $display("tb_lzss_bitstream_decoder: PASS");
    end else begin
      $display("tb_lzss_bitstream_decoder: FAIL");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #2000000;
    $display("tb_lzss_bitstream_decoder: FAIL");
    $finish;
  end

endmodule
